FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/gda_pkg.sv
// Shared types, constants and calendar helpers for the date arithmetic block.
package gda_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned OFF_W  = 17;
  localparam int unsigned DIFF_W = 23;
  localparam int unsigned YS_W   = 15;   // March-based year biased by 400
  localparam int unsigned SER_W  = 25;   // serial day number, signed
  localparam int unsigned DT_W   = 10;   // day-of-year term, signed

  localparam logic [YS_W-1:0] YEAR_BIAS  = 15'd400;
  localparam logic [YS_W-1:0] WALK_SPAN  = 15'd180;
  localparam logic signed [SER_W-1:0] SER_BIAS = 25'sd865565;
  localparam logic signed [SER_W-1:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [15:0] YEAR_MAX = 16'sd9999;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_A  = 2'd0,
    SRC_B  = 2'd1,
    SRC_Y  = 2'd2,
    SRC_Y1 = 2'd3
  } src_e;

  typedef struct packed {
    logic load;      // capture a new request
    src_e src;       // year and day term fed to the serial unit
    logic civ1;      // serial unit, first half
    logic civ2;      // serial unit, second half
    logic save_a;    // keep serial of A
    logic diff;      // form the saturated difference
    logic shift;     // form target serial and walk start year
    logic set_base;  // keep current year start
    logic step_y;    // advance walk year
    logic doy;       // form day of year
    logic date;      // split day of year into month and day
    logic out_load;  // move result into the output register
  } gda_cmd_t;

  typedef struct packed {
    op_e  op;
    logic reached;   // target serial at or past the probed year start
    logic out_free;
  } gda_sts_t;

  // Days before each month of a March-based year (month 0 is March).
  function automatic logic [8:0] gda_cum_days(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Day-of-year term of a date, with out-of-range months clamped to 1..12.
  function automatic logic signed [DT_W-1:0] gda_day_term(input logic [MON_W-1:0] month,
                                                          input logic [DAY_W-1:0] day);
    logic [3:0] mc;
    logic [3:0] mp;
    mc = (month < 4'd1) ? 4'd1 : ((month > 4'd12) ? 4'd12 : month);
    mp = (mc > 4'd2) ? (mc - 4'd3) : (mc + 4'd9);
    return $signed({1'b0, gda_cum_days(mp)}) + $signed({5'b0, day}) - 10'sd1;
  endfunction

  // March-based year plus the bias that keeps it non-negative.
  function automatic logic [YS_W-1:0] gda_shift_year(input logic [YEAR_W-1:0] year,
                                                     input logic [MON_W-1:0] month);
    return {1'b0, year} + YEAR_BIAS - {14'b0, (month <= 4'd2)};
  endfunction

endpackage

FILE: rtl/core/gregorian_date_arithmetic.sv
// Top level of the Gregorian date arithmetic block.
// Each request carries date A, date B, a signed day offset and an operation:
// add moves A forward by the offset, subtract moves it back, difference gives
// the signed day count from B to A (saturated to the 23-bit range), and the
// no-operation code returns zeros. Every result also compares A with B field
// by field. A shifted date outside years 0 to 9999 comes back as all zeros
// with out_of_range set; a difference with a year above 9999 sets the flag
// too. Dates are turned into serial day numbers by a unit whose first and
// second half each use one constant multiply; a shift then walks a
// March-based year upward from 180 years before A, probing one year start
// at a time, and splits the remaining day of year into month and day. One
// request is in work at a time; the next is taken once the current result
// sits in the output register, even if the consumer has not yet taken it.
`include "assert_macros.svh"

module gregorian_date_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
  // day_b[45:41], day_offset[62:46], zero pad [63]
  input  logic [63:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_year[13:0], result_month[17:14], result_day[22:18],
  // day_difference[45:23], a_greater[46], a_equal[47]
  output logic [47:0] m_axis_tdata_o,
  // out_of_range[0]
  output logic [0:0]  m_axis_tuser_o
);
  import gda_pkg::*;

  gda_cmd_t cmd;
  gda_sts_t sts;

  logic [YEAR_W-1:0]        result_year;
  logic [MON_W-1:0]         result_month;
  logic [DAY_W-1:0]         result_day;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     a_greater, a_equal, out_of_range;

  gda_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gda_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (s_axis_tuser_i),
    .year_a_i         (s_axis_tdata_i[13:0]),
    .month_a_i        (s_axis_tdata_i[17:14]),
    .day_a_i          (s_axis_tdata_i[22:18]),
    .year_b_i         (s_axis_tdata_i[36:23]),
    .month_b_i        (s_axis_tdata_i[40:37]),
    .day_b_i          (s_axis_tdata_i[45:41]),
    .day_offset_i     ($signed(s_axis_tdata_i[62:46])),
    .m_valid_o        (m_axis_tvalid_o),
    .m_ready_i        (m_axis_tready_i),
    .result_year_o    (result_year),
    .result_month_o   (result_month),
    .result_day_o     (result_day),
    .day_difference_o (day_difference),
    .a_greater_o      (a_greater),
    .a_equal_o        (a_equal),
    .out_of_range_o   (out_of_range)
  );

  // pack the result fields, lowest field first
  assign m_axis_tdata_o = {a_equal, a_greater, day_difference,
                           result_day, result_month, result_year};
  assign m_axis_tuser_o = out_of_range;

  // drop the input side to busy right after a request is taken
  `ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // hold date fields at zero on an out-of-range result
  `ASSERT_IMPLY(a_oor_zero_date, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o[22:0] == 23'd0)
  // never give a date and a day count in the same result
  `ASSERT_IMPLY(a_date_no_diff, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[17:14] != 4'd0), m_axis_tdata_o[45:23] == 23'd0)
  // never flag A as both later than and equal to B
  `ASSERT_IMPLY(a_cmp_exclusive, clk_i, rst_ni, m_axis_tvalid_o, !(m_axis_tdata_o[46] && m_axis_tdata_o[47]))

endmodule

FILE: rtl/core/gda_ctrl.sv
// Sequencer that steps the date datapath through each request.
module gda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  gda_pkg::gda_sts_t sts_i,
  output gda_pkg::gda_cmd_t cmd_o
);
  import gda_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SA1   = 4'd1;
  localparam logic [3:0] ST_SA2   = 4'd2;
  localparam logic [3:0] ST_SB1   = 4'd3;
  localparam logic [3:0] ST_SB2   = 4'd4;
  localparam logic [3:0] ST_DIFF  = 4'd5;
  localparam logic [3:0] ST_SHIFT = 4'd6;
  localparam logic [3:0] ST_ST1   = 4'd7;
  localparam logic [3:0] ST_ST2   = 4'd8;
  localparam logic [3:0] ST_BASE  = 4'd9;
  localparam logic [3:0] ST_NX1   = 4'd10;
  localparam logic [3:0] ST_NX2   = 4'd11;
  localparam logic [3:0] ST_CMP   = 4'd12;
  localparam logic [3:0] ST_DOY   = 4'd13;
  localparam logic [3:0] ST_DATE  = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src = SRC_A;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SA1;
        end
      end
      ST_SA1: begin
        cmd_o.src  = SRC_A;
        cmd_o.civ1 = 1'b1;
        state_d    = ST_SA2;
      end
      ST_SA2: begin
        cmd_o.src  = SRC_A;
        cmd_o.civ2 = 1'b1;
        case (sts_i.op)
          OP_ADD:  state_d = ST_SHIFT;
          OP_SUB:  state_d = ST_SHIFT;
          OP_DIFF: state_d = ST_SB1;
          default: state_d = ST_FIN;
        endcase
      end
      ST_SB1: begin
        cmd_o.src    = SRC_B;
        cmd_o.civ1   = 1'b1;
        cmd_o.save_a = 1'b1;
        state_d      = ST_SB2;
      end
      ST_SB2: begin
        cmd_o.src  = SRC_B;
        cmd_o.civ2 = 1'b1;
        state_d    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_FIN;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = ST_ST1;
      end
      ST_ST1: begin
        cmd_o.src  = SRC_Y;
        cmd_o.civ1 = 1'b1;
        state_d    = ST_ST2;
      end
      ST_ST2: begin
        cmd_o.src  = SRC_Y;
        cmd_o.civ2 = 1'b1;
        state_d    = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.set_base = 1'b1;
        state_d        = ST_NX1;
      end
      ST_NX1: begin
        cmd_o.src  = SRC_Y1;
        cmd_o.civ1 = 1'b1;
        state_d    = ST_NX2;
      end
      ST_NX2: begin
        cmd_o.src  = SRC_Y1;
        cmd_o.civ2 = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        // advance while the target lies in a later year
        if (sts_i.reached) begin
          cmd_o.set_base = 1'b1;
          cmd_o.step_y   = 1'b1;
          state_d        = ST_NX1;
        end else begin
          state_d = ST_DOY;
        end
      end
      ST_DOY: begin
        cmd_o.doy = 1'b1;
        state_d   = ST_DATE;
      end
      ST_DATE: begin
        cmd_o.date = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/gda_dpath.sv
// Datapath: serial day unit, year walk, month split and result registers.
module gda_dpath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gda_pkg::gda_cmd_t                       cmd_i,
  output gda_pkg::gda_sts_t                       sts_o,
  input  logic [1:0]                              operation_i,
  input  logic [gda_pkg::YEAR_W-1:0]              year_a_i,
  input  logic [gda_pkg::MON_W-1:0]               month_a_i,
  input  logic [gda_pkg::DAY_W-1:0]               day_a_i,
  input  logic [gda_pkg::YEAR_W-1:0]              year_b_i,
  input  logic [gda_pkg::MON_W-1:0]               month_b_i,
  input  logic [gda_pkg::DAY_W-1:0]               day_b_i,
  input  logic signed [gda_pkg::OFF_W-1:0]        day_offset_i,
  output logic                                    m_valid_o,
  input  logic                                    m_ready_i,
  output logic [gda_pkg::YEAR_W-1:0]              result_year_o,
  output logic [gda_pkg::MON_W-1:0]               result_month_o,
  output logic [gda_pkg::DAY_W-1:0]               result_day_o,
  output logic signed [gda_pkg::DIFF_W-1:0]       day_difference_o,
  output logic                                    a_greater_o,
  output logic                                    a_equal_o,
  output logic                                    out_of_range_o
);
  import gda_pkg::*;

  // request registers
  op_e                      op_q;
  logic [YS_W-1:0]          ya_s_q, yb_s_q;
  logic signed [DT_W-1:0]   dta_q, dtb_q;
  logic signed [OFF_W-1:0]  off_q;
  logic                     big_year_q, gt_q, eq_q;

  // serial unit and walk registers
  logic [7:0]               q100_q;
  logic signed [SER_W-1:0]  part_q, acc_q, sa_q, s_q, base_q;
  logic [YS_W-1:0]          y_q;
  logic [8:0]               doy_q;

  // result and output registers
  logic [YEAR_W-1:0]        res_year_q, out_year_q;
  logic [MON_W-1:0]         res_month_q, out_month_q;
  logic [DAY_W-1:0]         res_day_q, out_day_q;
  logic signed [DIFF_W-1:0] res_diff_q, out_diff_q;
  logic                     res_oor_q, out_oor_q, out_gt_q, out_eq_q;
  logic                     out_valid_q;

  logic [YS_W-1:0]          ysel;
  logic signed [DT_W-1:0]   dtsel;
  logic [27:0]              y5243;
  logic [23:0]              y365;
  logic signed [SER_W-1:0]  part_d, acc_d, off_x, diff_full, diff_sat, doy_full;
  logic [3:0]               mp;
  logic [8:0]               day_rem;
  logic signed [15:0]       yr;
  logic                     yr_oor;

  always_comb begin
    case (cmd_i.src)
      SRC_A:   ysel = ya_s_q;
      SRC_B:   ysel = yb_s_q;
      SRC_Y:   ysel = y_q;
      SRC_Y1:  ysel = y_q + 15'd1;
      default: ysel = y_q;
    endcase
    case (cmd_i.src)
      SRC_A:   dtsel = dta_q;
      SRC_B:   dtsel = dtb_q;
      default: dtsel = '0;
    endcase
  end

  // serial = 365Y + Y/4 - Y/100 + Y/400 + day term - bias, split over civ1 and civ2
  assign y5243  = 28'(ysel) * 28'd5243;
  assign y365   = 24'(ysel) * 24'd365;
  assign part_d = $signed(SER_W'(ysel[YS_W-1:2]))
                + $signed({{(SER_W-DT_W){dtsel[DT_W-1]}}, dtsel}) - SER_BIAS;
  assign acc_d  = part_q + $signed(SER_W'(y365)) - $signed(SER_W'(q100_q))
                + $signed(SER_W'(q100_q[7:2]));

  assign off_x     = {{(SER_W-OFF_W){off_q[OFF_W-1]}}, off_q};
  assign diff_full = sa_q - acc_q;
  assign diff_sat  = (diff_full > DIFF_MAX) ? DIFF_MAX :
                     ((diff_full < -DIFF_MAX) ? -DIFF_MAX : diff_full);
  assign doy_full  = s_q - base_q;

  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy_q >= gda_cum_days(4'(i))) begin
        mp = 4'(i);
      end
    end
    day_rem = doy_q - gda_cum_days(mp) + 9'd1;
    yr      = $signed({1'b0, y_q}) - $signed({1'b0, YEAR_BIAS})
            + $signed({15'b0, (mp >= 4'd10)});
    yr_oor  = (yr < 16'sd0) || (yr > YEAR_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_e'(operation_i);
      ya_s_q     <= gda_shift_year(year_a_i, month_a_i);
      yb_s_q     <= gda_shift_year(year_b_i, month_b_i);
      dta_q      <= gda_day_term(month_a_i, day_a_i);
      dtb_q      <= gda_day_term(month_b_i, day_b_i);
      off_q      <= day_offset_i;
      big_year_q <= (year_a_i > 14'd9999) || (year_b_i > 14'd9999);
      gt_q       <= {year_a_i, month_a_i, day_a_i} > {year_b_i, month_b_i, day_b_i};
      eq_q       <= {year_a_i, month_a_i, day_a_i} == {year_b_i, month_b_i, day_b_i};
      res_year_q  <= '0;
      res_month_q <= '0;
      res_day_q   <= '0;
      res_diff_q  <= '0;
      res_oor_q   <= 1'b0;
    end
    if (cmd_i.civ1) begin
      q100_q <= y5243[26:19];
      part_q <= part_d;
    end
    if (cmd_i.civ2) begin
      acc_q <= acc_d;
    end
    if (cmd_i.save_a) begin
      sa_q <= acc_q;
    end
    if (cmd_i.diff) begin
      res_diff_q <= diff_sat[DIFF_W-1:0];
      res_oor_q  <= big_year_q;
    end
    if (cmd_i.shift) begin
      s_q <= (op_q == OP_SUB) ? (acc_q - off_x) : (acc_q + off_x);
      y_q <= ya_s_q - WALK_SPAN;
    end
    if (cmd_i.set_base) begin
      base_q <= acc_q;
    end
    if (cmd_i.step_y) begin
      y_q <= y_q + 15'd1;
    end
    if (cmd_i.doy) begin
      doy_q <= doy_full[8:0];
    end
    if (cmd_i.date) begin
      res_oor_q   <= yr_oor;
      res_year_q  <= yr_oor ? '0 : yr[YEAR_W-1:0];
      res_month_q <= yr_oor ? '0 : ((mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9));
      res_day_q   <= yr_oor ? '0 : day_rem[DAY_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_year_q  <= res_year_q;
      out_month_q <= res_month_q;
      out_day_q   <= res_day_q;
      out_diff_q  <= res_diff_q;
      out_oor_q   <= res_oor_q;
      out_gt_q    <= gt_q;
      out_eq_q    <= eq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.reached  = (s_q >= acc_q);
  assign sts_o.out_free = !out_valid_q || m_ready_i;

  assign m_valid_o        = out_valid_q;
  assign result_year_o    = out_year_q;
  assign result_month_o   = out_month_q;
  assign result_day_o     = out_day_q;
  assign day_difference_o = out_diff_q;
  assign a_greater_o      = out_gt_q;
  assign a_equal_o        = out_eq_q;
  assign out_of_range_o   = out_oor_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the Gregorian date arithmetic block.
module tb_top;
  import gda_pkg::*;

  localparam longint LAST_YEAR   = 9999;
  localparam longint SPAN_LIMIT  = 4194303;  // largest 23-bit signed day count
  localparam int     CYCLE_LIMIT = 800000;   // budget for the whole run before the watchdog stops it
  localparam int     DRAIN_CYCLES = 64;

  // One request as the producer sees it.
  typedef struct {
    op_e                     op;
    logic [YEAR_W-1:0]       year_a;
    logic [MON_W-1:0]        month_a;
    logic [DAY_W-1:0]        day_a;
    logic [YEAR_W-1:0]       year_b;
    logic [MON_W-1:0]        month_b;
    logic [DAY_W-1:0]        day_b;
    logic signed [OFF_W-1:0] offset;
  } date_request_t;

  // One result as the consumer sees it.
  typedef struct {
    logic [YEAR_W-1:0]        year;
    logic [MON_W-1:0]         month;
    logic [DAY_W-1:0]         day;
    logic signed [DIFF_W-1:0] span;
    logic                     later;
    logic                     same;
    logic                     out_of_range;
  } date_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
  // day_b[45:41], day_offset[62:46], zero pad [63]
  logic [63:0] s_axis_tdata_i;
  // operation[1:0]
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // result_year[13:0], result_month[17:14], result_day[22:18],
  // day_difference[45:23], a_greater[46], a_equal[47]
  logic [47:0] m_axis_tdata_o;
  // out_of_range[0]
  logic [0:0]  m_axis_tuser_o;

  date_result_t expected_dates[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  logic         steady_flow = 1'b0;  // suppress idling on both sides

  gregorian_date_arithmetic u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Day number of a date, day 0 being 1970-01-01; months clamp to 1..12 and
  // surplus days simply run on into the following months.
  function automatic longint to_day_number(input longint y, input longint m,
                                           input longint d);
    longint cycle, year_in_cycle, day_in_year, day_in_cycle;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    // Count years from March so the leap day falls at the end of the year.
    if (m <= 2) y = y - 1;
    cycle         = (y >= 0 ? y : y - 399) / 400;
    year_in_cycle = y - cycle * 400;
    day_in_year   = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    day_in_cycle  = year_in_cycle * 365 + year_in_cycle / 4 - year_in_cycle / 100
                    + day_in_year;
    return cycle * 146097 + day_in_cycle - 719468;
  endfunction

  function automatic void from_day_number(input longint n, output longint y,
                                          output longint m, output longint d);
    longint cycle, day_in_cycle, year_in_cycle, day_in_year, march_month;
    n            = n + 719468;
    cycle        = (n >= 0 ? n : n - 146096) / 146097;
    day_in_cycle = n - cycle * 146097;
    year_in_cycle = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                     - day_in_cycle / 146096) / 365;
    day_in_year  = day_in_cycle - (365 * year_in_cycle + year_in_cycle / 4
                                   - year_in_cycle / 100);
    march_month  = (5 * day_in_year + 2) / 153;
    d = day_in_year - (153 * march_month + 2) / 5 + 1;
    m = march_month < 10 ? march_month + 3 : march_month - 9;
    y = year_in_cycle + cycle * 400 + (m <= 2 ? 1 : 0);
  endfunction

  function automatic date_result_t predict_date_result(input date_request_t r);
    date_result_t p;
    longint ya, ma, da, yb, mb, db, n, y, m, d, span;
    ya = r.year_a;  ma = r.month_a;  da = r.day_a;
    yb = r.year_b;  mb = r.month_b;  db = r.day_b;
    p.year = '0;  p.month = '0;  p.day = '0;  p.span = '0;  p.out_of_range = 1'b0;
    // The comparison works on the raw fields, odd months included.
    p.same  = (ya == yb && ma == mb && da == db);
    p.later = (ya > yb || (ya == yb && (ma > mb || (ma == mb && da > db))));
    case (r.op)
      OP_ADD, OP_SUB: begin
        n = to_day_number(ya, ma, da);
        n = (r.op == OP_ADD) ? n + longint'(r.offset) : n - longint'(r.offset);
        from_day_number(n, y, m, d);
        if (y < 0 || y > LAST_YEAR) begin
          p.out_of_range = 1'b1;
        end else begin
          p.year  = y[YEAR_W-1:0];
          p.month = m[MON_W-1:0];
          p.day   = d[DAY_W-1:0];
        end
      end
      OP_DIFF: begin
        span = to_day_number(ya, ma, da) - to_day_number(yb, mb, db);
        if (span > SPAN_LIMIT) span = SPAN_LIMIT;
        if (span < -SPAN_LIMIT) span = -SPAN_LIMIT;
        p.span = span[DIFF_W-1:0];
        p.out_of_range = (ya > LAST_YEAR || yb > LAST_YEAR);
      end
      default: ;
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Producer side
  // ---------------------------------------------------------------------------

  function automatic date_request_t make_request(input op_e op,
                                                 input int ya, input int ma, input int da,
                                                 input int yb, input int mb, input int db,
                                                 input int off);
    date_request_t r;
    r.op      = op;
    r.year_a  = YEAR_W'(ya);  r.month_a = MON_W'(ma);  r.day_a = DAY_W'(da);
    r.year_b  = YEAR_W'(yb);  r.month_b = MON_W'(mb);  r.day_b = DAY_W'(db);
    r.offset  = OFF_W'(off);
    return r;
  endfunction

  // Mostly real calendar dates, a share near the year limits, and some raw
  // field noise (years above 9999, month 0 or 13..15, days past month end).
  function automatic void random_date(output logic [YEAR_W-1:0] y,
                                      output logic [MON_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
    int unsigned yr, mo, last_day;
    if ($urandom_range(99) < 15) begin
      y = YEAR_W'($urandom_range(16383));
      m = MON_W'($urandom_range(15));
      d = DAY_W'($urandom_range(31));
    end else begin
      case ($urandom_range(9))
        0:       yr = $urandom_range(3);
        1:       yr = $urandom_range(9999, 9996);
        default: yr = $urandom_range(9999);
      endcase
      mo = $urandom_range(12, 1);
      case (mo)
        4, 6, 9, 11: last_day = 30;
        2: last_day = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
        default: last_day = 31;
      endcase
      y = YEAR_W'(yr);
      m = MON_W'(mo);
      // Lean on month ends, where the carries happen.
      d = DAY_W'(($urandom_range(3) == 0) ? last_day : $urandom_range(last_day, 1));
    end
  endfunction

  function automatic date_request_t random_request();
    date_request_t r;
    if ($urandom_range(99) < 5) begin
      r.op = OP_NONE;
    end else begin
      case ($urandom_range(2))
        0:       r.op = OP_ADD;
        1:       r.op = OP_SUB;
        default: r.op = OP_DIFF;
      endcase
    end
    random_date(r.year_a, r.month_a, r.day_a);
    case ($urandom_range(9))
      0, 1: begin
        r.year_b = r.year_a;  r.month_b = r.month_a;  r.day_b = r.day_a;
      end
      2: begin
        r.year_b = r.year_a;  r.month_b = r.month_a;
        r.day_b  = DAY_W'($urandom_range(31, 1));
      end
      default: random_date(r.year_b, r.month_b, r.day_b);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: r.offset = OFF_W'(int'($urandom_range(800)) - 400);
      default:       r.offset = OFF_W'($urandom_range(131071));
    endcase
    return r;
  endfunction

  // Present one request, hold it until taken, and record its expected result.
  // Valid stays high into the next request unless a gap is drawn.
  task automatic send_request(input date_request_t r);
    int unsigned gap;
    gap = (!steady_flow && $urandom_range(99) < 16) ? $urandom_range(8, 1) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, r.offset, r.day_b, r.month_b, r.year_b,
                        r.day_a, r.month_a, r.year_a};
    s_axis_tuser_i  <= r.op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_dates.push_back(predict_date_result(r));
  endtask

  // ---------------------------------------------------------------------------
  // Consumer side and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Stall the result side at random except during the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready_i <= steady_flow || ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = expected_dates.pop_front();
        if (m_axis_tdata_o[13:0] != want.year)
          report_mismatch($sformatf("result_year got %0d expected %0d",
                                    m_axis_tdata_o[13:0], want.year));
        if (m_axis_tdata_o[17:14] != want.month)
          report_mismatch($sformatf("result_month got %0d expected %0d",
                                    m_axis_tdata_o[17:14], want.month));
        if (m_axis_tdata_o[22:18] != want.day)
          report_mismatch($sformatf("result_day got %0d expected %0d",
                                    m_axis_tdata_o[22:18], want.day));
        if (m_axis_tdata_o[45:23] != want.span)
          report_mismatch($sformatf("day_difference got %0d expected %0d",
                                    $signed(m_axis_tdata_o[45:23]), want.span));
        if (m_axis_tdata_o[46] != want.later)
          report_mismatch($sformatf("a_greater got %0b expected %0b",
                                    m_axis_tdata_o[46], want.later));
        if (m_axis_tdata_o[47] != want.same)
          report_mismatch($sformatf("a_equal got %0b expected %0b",
                                    m_axis_tdata_o[47], want.same));
        if (m_axis_tuser_o[0] != want.out_of_range)
          report_mismatch($sformatf("out_of_range got %0b expected %0b",
                                    m_axis_tuser_o[0], want.out_of_range));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gregorian_date_arithmetic test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Shifts across leap days, year limits, offset extremes and odd fields.
  task automatic test_shift_calendar();
    send_request(make_request(OP_ADD, 2000, 2, 28, 2000, 2, 28, 1));       // leap century
    send_request(make_request(OP_ADD, 1900, 2, 28, 1900, 3, 1, 1));        // plain century
    send_request(make_request(OP_SUB, 2000, 3, 1, 1999, 12, 31, 1));
    send_request(make_request(OP_ADD, 9999, 12, 31, 0, 1, 1, 1));          // past the top
    send_request(make_request(OP_SUB, 0, 1, 1, 9999, 12, 31, 1));          // below year 0
    send_request(make_request(OP_ADD, 0, 1, 1, 0, 1, 1, 65535));
    send_request(make_request(OP_ADD, 9999, 12, 31, 9999, 12, 31, -65536));
    send_request(make_request(OP_SUB, 5000, 6, 15, 5000, 6, 14, -65535));  // reversed
    send_request(make_request(OP_SUB, 9999, 12, 31, 1, 1, 1, 65535));
    send_request(make_request(OP_ADD, 2024, 2, 31, 2024, 3, 2, 0));        // day past month end
    send_request(make_request(OP_ADD, 2023, 3, 0, 2023, 2, 28, 0));        // day zero
    send_request(make_request(OP_ADD, 2023, 0, 15, 2023, 1, 15, 10));      // month zero
    send_request(make_request(OP_SUB, 2023, 15, 31, 2023, 12, 31, 0));     // month 15
    send_request(make_request(OP_ADD, 16383, 15, 31, 16383, 15, 31, 0));   // all ones
  endtask

  // Day counts, saturation, comparison ordering and the idle operation.
  task automatic test_difference_compare();
    send_request(make_request(OP_DIFF, 2000, 1, 1, 2000, 1, 1, 0));
    send_request(make_request(OP_DIFF, 9999, 12, 31, 0, 1, 1, 0));
    send_request(make_request(OP_DIFF, 0, 1, 1, 9999, 12, 31, 0));
    send_request(make_request(OP_DIFF, 16383, 12, 31, 0, 1, 1, 0));        // saturate high
    send_request(make_request(OP_DIFF, 0, 1, 1, 16383, 12, 31, 0));        // saturate low
    send_request(make_request(OP_DIFF, 2024, 3, 1, 2024, 2, 28, 0));
    send_request(make_request(OP_DIFF, 2024, 2, 28, 2024, 2, 29, 0));
    send_request(make_request(OP_NONE, 1234, 5, 6, 1234, 5, 7, 777));
    send_request(make_request(OP_NONE, 0, 0, 0, 16383, 15, 31, -1));
    send_request(make_request(OP_ADD, 2023, 13, 1, 2023, 12, 31, 5));      // raw month compare
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_request(random_request());
  endtask

  // Long stretch with no input gaps and the result side always ready.
  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    repeat (count) send_request(random_request());
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_ADD;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_shift_calendar();
    test_difference_compare();
    test_random_mix(76);
    test_back_to_back(40);

    s_axis_tvalid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    // Watch a little longer for stray results.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("gregorian_date_arithmetic test passed");
    end else begin
      $display("gregorian_date_arithmetic test failed");
    end
    $finish;
  end

endmodule
